>>> sv/ihw_pkg.sv
package ihw_pkg;

  localparam int          CELLS       = 16;
  localparam logic [4:0]  REC_BYTES   = 5'(CELLS);
  localparam logic [15:0] WRAP_OFFSET = 16'hFFF0;

  localparam logic        KIND_DATA = 1'b0;
  localparam logic        KIND_END  = 1'b1;

  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_ONE   = 8'h31;
  localparam logic [7:0]  CH_TWO   = 8'h32;
  localparam logic [7:0]  CH_FOUR  = 8'h34;
  localparam logic [7:0]  CH_UPF   = 8'h46;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_LF    = 8'h0A;

  localparam logic [4:0]  ADDR_LAST  = 5'd16;
  localparam logic [4:0]  DHEAD_LAST = 5'd8;
  localparam logic [4:0]  DTAIL_LAST = 5'd3;
  localparam logic [4:0]  EOF_LAST   = 5'd12;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ADDR  = 7'b0000010,
    S_DHEAD = 7'b0000100,
    S_ALIGN = 7'b0001000,
    S_DBODY = 7'b0010000,
    S_DTAIL = 7'b0100000,
    S_EOF   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic       shift;
    logic [7:0] head;
  } chain_ctl_t;

  // lower-case hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = CH_ZERO + {4'h0, v};
    end else begin
      c = 8'h57 + {4'h0, v};
    end
    return c;
  endfunction

  // ":02000004" hhhh ss CR LF
  function automatic logic [7:0] addr_char(input logic [4:0] idx, input logic [15:0] upper);
    logic [7:0] sum;
    logic [7:0] c;
    sum = 8'h00 - (8'd6 + upper[15:8] + upper[7:0]);
    unique case (idx)
      5'd0:    c = CH_COLON;
      5'd2:    c = CH_TWO;
      5'd8:    c = CH_FOUR;
      5'd9:    c = hex_char(upper[15:12]);
      5'd10:   c = hex_char(upper[11:8]);
      5'd11:   c = hex_char(upper[7:4]);
      5'd12:   c = hex_char(upper[3:0]);
      5'd13:   c = hex_char(sum[7:4]);
      5'd14:   c = hex_char(sum[3:0]);
      5'd15:   c = CH_CR;
      5'd16:   c = CH_LF;
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

  // ":00000001FF" CR LF
  function automatic logic [7:0] eof_char(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:    c = CH_COLON;
      5'd8:    c = CH_ONE;
      5'd9:    c = CH_UPF;
      5'd10:   c = CH_UPF;
      5'd11:   c = CH_CR;
      5'd12:   c = CH_LF;
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

endpackage

>>> sv/ihw_cell.sv
module ihw_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] d,
  output logic [7:0] q
);
  logic [7:0] q_r;
  logic [7:0] q_nxt;

  assign q_nxt = shift_en ? d : q_r;

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;
endmodule

>>> sv/ihw_chain.sv
module ihw_chain (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [7:0]        d_in,
  output ihw_pkg::chain_ctl_t status
);
  import ihw_pkg::*;

  logic [7:0] cell_q [CELLS];

  // new bytes enter at cell 0, the oldest byte leaves from the last cell
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      ihw_cell u_cell (.clk(clk), .shift_en(shift_en), .d(d_in), .q(cell_q[i]));
    end else begin : g_next
      ihw_cell u_cell (.clk(clk), .shift_en(shift_en), .d(cell_q[i-1]), .q(cell_q[i]));
    end
  end

  assign status.shift = shift_en;
  assign status.head  = cell_q[CELLS-1];
endmodule

>>> sv/intel_hex_record_writer.sv
// channel   direction  handshake            payload
// cfg       in         cfg_valid/cfg_ready  cfg_start_kilobytes[21:0]
// in        in         in_valid/in_stall    in_kind, in_data_byte[7:0]
// out       out        out_valid/out_stall  out_text_char[7:0], out_last_of_run
//
// one character per cycle while out is not stalled; one request at a time.
// a byte that completes no record emits nothing; first request adds a 17-char
// extended address record; a full record is 45 chars, a short one of n bytes
// 2n+13 chars plus an align step; end adds 13 chars; rst_n is synchronous;
// cfg_ready stays high; config must be written only while idle; not enforced.
// a new request is taken while the last character still waits in the out register.
module intel_hex_record_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [21:0] cfg_start_kilobytes,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_text_char,
  output logic        out_last_of_run
);
  import ihw_pkg::*;

  state_t      state_r, state_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        nib_r, nib_nxt;
  logic        kind_r, kind_nxt;
  logic [4:0]  count_r, count_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] upper_r, upper_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic        hdr_r, hdr_nxt;
  logic [21:0] start_kb_r;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_last_r;

  logic        in_acc;
  logic        emit, emit_ok, shift;
  logic [7:0]  ch;
  logic        last;
  logic [7:0]  dsum;
  logic [4:0]  count_inc;
  chain_ctl_t  chain_st;

  ihw_chain u_chain (
    .clk     (clk),
    .shift_en(shift),
    .d_in    (in_data_byte),
    .status  (chain_st)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign emit_ok   = !out_valid_r || !out_stall;
  assign count_inc = count_r + 5'd1;
  assign dsum      = 8'h00 - ({3'b000, count_r} + offset_r[15:8] + offset_r[7:0] + sum_r);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    nib_nxt    = nib_r;
    kind_nxt   = kind_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    upper_nxt  = upper_r;
    offset_nxt = offset_r;
    hdr_nxt    = hdr_r;
    emit       = 1'b0;
    shift      = 1'b0;
    ch         = CH_ZERO;
    last       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt = in_kind;
          idx_nxt  = 5'd0;
          if (in_kind == KIND_DATA) begin
            shift     = 1'b1;
            count_nxt = count_inc;
            sum_nxt   = sum_r + in_data_byte;
            if (hdr_r && count_inc == REC_BYTES) begin
              state_nxt = S_DHEAD;
            end
          end else if (hdr_r) begin
            state_nxt = (count_r != 5'd0) ? S_DHEAD : S_EOF;
          end
          if (!hdr_r) begin
            upper_nxt  = start_kb_r[21:6];
            offset_nxt = {start_kb_r[5:0], 10'b0};
            state_nxt  = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        emit = 1'b1;
        ch   = addr_char(idx_r, upper_r);
        last = (idx_r == ADDR_LAST) && (kind_r == KIND_DATA) && (count_r != REC_BYTES);
        if (emit_ok) begin
          if (idx_r == ADDR_LAST) begin
            hdr_nxt = 1'b1;
            idx_nxt = 5'd0;
            if (kind_r == KIND_DATA) begin
              state_nxt = (count_r == REC_BYTES) ? S_DHEAD : S_IDLE;
            end else begin
              state_nxt = (count_r != 5'd0) ? S_DHEAD : S_EOF;
            end
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      S_DHEAD: begin
        emit = 1'b1;
        unique case (idx_r)
          5'd0:    ch = CH_COLON;
          5'd1:    ch = hex_char({3'b000, count_r[4]});
          5'd2:    ch = hex_char(count_r[3:0]);
          5'd3:    ch = hex_char(offset_r[15:12]);
          5'd4:    ch = hex_char(offset_r[11:8]);
          5'd5:    ch = hex_char(offset_r[7:4]);
          5'd6:    ch = hex_char(offset_r[3:0]);
          default: ch = CH_ZERO;
        endcase
        if (emit_ok) begin
          if (idx_r == DHEAD_LAST) begin
            nib_nxt = 1'b0;
            if (count_r == REC_BYTES) begin
              state_nxt = S_DBODY;
              idx_nxt   = 5'd0;
            end else begin
              state_nxt = S_ALIGN;
              idx_nxt   = count_r;
            end
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      S_ALIGN: begin
        // move a short record's oldest byte up to the head cell
        shift = 1'b1;
        if (idx_r == REC_BYTES - 5'd1) begin
          state_nxt = S_DBODY;
          idx_nxt   = 5'd0;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end
      S_DBODY: begin
        emit = 1'b1;
        ch   = nib_r ? hex_char(chain_st.head[3:0]) : hex_char(chain_st.head[7:4]);
        if (emit_ok) begin
          if (!nib_r) begin
            nib_nxt = 1'b1;
          end else begin
            nib_nxt = 1'b0;
            shift   = 1'b1;
            if (idx_r == count_r - 5'd1) begin
              state_nxt = S_DTAIL;
              idx_nxt   = 5'd0;
            end else begin
              idx_nxt = idx_r + 5'd1;
            end
          end
        end
      end
      S_DTAIL: begin
        emit = 1'b1;
        unique case (idx_r)
          5'd0:    ch = hex_char(dsum[7:4]);
          5'd1:    ch = hex_char(dsum[3:0]);
          5'd2:    ch = CH_CR;
          default: ch = CH_LF;
        endcase
        last = (idx_r == DTAIL_LAST) && (kind_r == KIND_DATA) && (offset_r != WRAP_OFFSET);
        if (emit_ok) begin
          if (idx_r == DTAIL_LAST) begin
            count_nxt = 5'd0;
            sum_nxt   = 8'h00;
            idx_nxt   = 5'd0;
            if (kind_r == KIND_DATA) begin
              if (offset_r == WRAP_OFFSET) begin
                offset_nxt = 16'h0000;
                upper_nxt  = upper_r + 16'd1;
                state_nxt  = S_ADDR;
              end else begin
                offset_nxt = offset_r + 16'(REC_BYTES);
                state_nxt  = S_IDLE;
              end
            end else begin
              state_nxt = S_EOF;
            end
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      S_EOF: begin
        emit = 1'b1;
        ch   = eof_char(idx_r);
        last = (idx_r == EOF_LAST);
        if (emit_ok) begin
          if (idx_r == EOF_LAST) begin
            hdr_nxt   = 1'b0;
            count_nxt = 5'd0;
            sum_nxt   = 8'h00;
            idx_nxt   = 5'd0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 5'd0;
      nib_r       <= 1'b0;
      kind_r      <= KIND_DATA;
      count_r     <= 5'd0;
      sum_r       <= 8'h00;
      upper_r     <= 16'h0000;
      offset_r    <= 16'h0000;
      hdr_r       <= 1'b0;
      start_kb_r  <= 22'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      nib_r    <= nib_nxt;
      kind_r   <= kind_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      upper_r  <= upper_nxt;
      offset_r <= offset_nxt;
      hdr_r    <= hdr_nxt;
      if (cfg_valid && cfg_ready) begin
        start_kb_r <= cfg_start_kilobytes;
      end
      if (emit && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit && emit_ok) begin
      out_char_r <= ch;
      out_last_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_text_char   = out_char_r;
  assign out_last_of_run = out_last_r;
endmodule

>>> sv/ihw_checker.sv
module ihw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [21:0] cfg_start_kilobytes,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_kind,
  input logic [7:0]  in_data_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_text_char,
  input logic        out_last_of_run
);
  import ihw_pkg::*;

  logic legal_char;
  logic unused_ok;

  assign legal_char = (out_text_char >= CH_ZERO && out_text_char <= 8'h39) ||
                      (out_text_char >= 8'h61 && out_text_char <= 8'h66) ||
                      out_text_char == CH_COLON || out_text_char == CH_UPF ||
                      out_text_char == CH_CR || out_text_char == CH_LF;
  assign unused_ok  = cfg_valid ^ cfg_ready ^ (^cfg_start_kilobytes) ^ (^in_data_byte);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_text_char) && $stable(out_last_of_run))
    else $error("stalled character changed");

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == KIND_END |=> in_stall)
    else $error("end request produced no output");

  a_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> legal_char || unused_ok != unused_ok)
    else $error("character outside hex text set");

  a_last_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> out_text_char == CH_LF)
    else $error("run does not end on a line feed");
endmodule

bind intel_hex_record_writer ihw_checker u_ihw_checker (.*);
